/* src/dphm_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and register codes for the depth pixel height map projection
// no dependencies; imported by every module of the block

package dphm_pkg;

    // geometry of frame and map
    localparam int MAP_WIDTH  = 200;
    localparam int MAP_HEIGHT = 200;
    localparam int FRAME_ROWS = 480;
    localparam int FRAME_COLS = 848;

    // cell codes
    localparam logic [7:0] CELL_GROUND   = 8'd255;
    localparam logic [7:0] CELL_OBSTACLE = 8'd100;

    // datapath widths
    localparam int DIFF_W = 11;                 // signed pixel offset from centre
    localparam int AX_W   = 28;                 // offset times depth
    localparam int P_W    = 45;                 // back-projected point, Q20 mm
    localparam int PA_W   = 16 + P_W;           // coefficient times point
    localparam int PZ_W   = 16 + 17;            // coefficient times depth
    localparam int R_W    = 63;                 // rotated value, Q34 mm
    localparam int FRAC_W = 34;
    localparam int H_W    = R_W - FRAC_W;       // whole millimetres of magnitude
    localparam int Q_W    = 29;                 // centimetres of magnitude

    // x / 10 == (x * DIV10_MAGIC) >> 35 for any 32-bit unsigned x
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam int CFG_W = 48;

    typedef enum logic [2:0] {
        REG_PRINCIPAL = 3'd0,
        REG_INV_FOCAL = 3'd1,
        REG_ROT_ROW_0 = 3'd2,
        REG_ROT_ROW_1 = 3'd3,
        REG_ROT_ROW_2 = 3'd4,
        REG_GROUND    = 3'd5,
        REG_BAND      = 3'd6,
        REG_GND_VALID = 3'd7
    } t_reg_idx;

    localparam logic [19:0] RST_PRINCIPAL = 20'd249250;
    localparam logic [31:0] RST_INV_FOCAL = 32'd161876390;
    localparam logic [47:0] RST_ROT_ROW_0 = 48'd16384;
    localparam logic [47:0] RST_ROT_ROW_1 = 48'd1073741824;
    localparam logic [47:0] RST_ROT_ROW_2 = 48'd70368744177664;
    localparam logic [14:0] RST_GROUND    = 15'd0;
    localparam logic [9:0]  RST_BAND      = 10'd30;
    localparam logic        RST_GND_VALID = 1'b0;

    typedef struct packed {
        logic [9:0]  pixel_row;
        logic [9:0]  pixel_col;
        logic [15:0] depth_mm;
    } t_in;

    typedef struct packed {
        logic       write_enable;
        logic [7:0] map_row;
        logic [7:0] map_col;
        logic [7:0] cell_value;
    } t_out;

    typedef struct packed {
        logic [9:0]             cx;
        logic [9:0]             cy;
        logic [15:0]            inv_fx;
        logic [15:0]            inv_fy;
        logic [2:0][47:0]       rot;
        logic signed [14:0]     ground;
        logic [9:0]             band;
        logic                   gnd_valid;
    } t_cfg;

    // back-projected point handed from front end to rotation
    typedef struct packed {
        logic                   skip;
        logic signed [P_W-1:0]  px;
        logic signed [P_W-1:0]  py;
        logic [15:0]            depth;
    } t_proj;

    // rotated point handed from rotation to quantizer
    typedef struct packed {
        logic                   skip;
        logic signed [R_W-1:0]  rx;
        logic signed [R_W-1:0]  ry;
        logic signed [R_W-1:0]  rz;
    } t_rot;

endpackage

/* src/dphm_front.sv */
`timescale 1ns / 1ps
// front end: pixel filter and back-projection through principal point and 1/f
// three register stages; depends on dphm_pkg

module dphm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dphm_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  dphm_pkg::t_in        i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output dphm_pkg::t_proj      o_data
);
    import dphm_pkg::*;

    localparam logic [10:0] ROW_LIM = 11'(FRAME_ROWS - 2);
    localparam logic [10:0] COL_LIM = 11'(FRAME_COLS - 2);

    logic [2:0] w_stall;
    logic [2:0] r_vld, n_vld;

    logic                     r_skip1, n_skip1, r_skip2, n_skip2, r_skip3, n_skip3;
    logic signed [DIFF_W-1:0] r_dcol, n_dcol, r_drow, n_drow;
    logic [15:0]              r_dep1, n_dep1, r_dep2, n_dep2, r_dep3, n_dep3;
    logic signed [AX_W-1:0]   r_ax, n_ax, r_ay, n_ay;
    logic signed [P_W-1:0]    r_px, n_px, r_py, n_py;

    // a stage holds only while it has an item and the stage after it holds
    always_comb begin
        w_stall[2] = r_vld[2] & i_stall;
        w_stall[1] = r_vld[1] & w_stall[2];
        w_stall[0] = r_vld[0] & w_stall[1];
    end

    always_comb begin
        n_vld  = {r_vld[1], r_vld[0], i_valid};
        // odd rows or columns, and the last two rows or columns and anything past them, are dropped
        n_skip1 = i_data.pixel_row[0] | i_data.pixel_col[0]
                | ({1'b0, i_data.pixel_row} >= ROW_LIM)
                | ({1'b0, i_data.pixel_col} >= COL_LIM);
        n_dcol = $signed({1'b0, i_data.pixel_col}) - $signed({1'b0, i_cfg.cx});
        n_drow = $signed({1'b0, i_data.pixel_row}) - $signed({1'b0, i_cfg.cy});
        n_dep1 = i_data.depth_mm;

        n_skip2 = r_skip1;
        n_ax    = r_dcol * $signed({1'b0, r_dep1});
        n_ay    = r_drow * $signed({1'b0, r_dep1});
        n_dep2  = r_dep1;

        n_skip3 = r_skip2;
        n_px    = r_ax * $signed({1'b0, i_cfg.inv_fx});
        n_py    = r_ay * $signed({1'b0, i_cfg.inv_fy});
        n_dep3  = r_dep2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (!w_stall[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall[0]) begin
            r_skip1 <= n_skip1;
            r_dcol  <= n_dcol;
            r_drow  <= n_drow;
            r_dep1  <= n_dep1;
        end
        if (!w_stall[1]) begin
            r_skip2 <= n_skip2;
            r_ax    <= n_ax;
            r_ay    <= n_ay;
            r_dep2  <= n_dep2;
        end
        if (!w_stall[2]) begin
            r_skip3 <= n_skip3;
            r_px    <= n_px;
            r_py    <= n_py;
            r_dep3  <= n_dep3;
        end
    end

    assign o_stall      = w_stall[0];
    assign o_valid      = r_vld[2];
    assign o_data.skip  = r_skip3;
    assign o_data.px    = r_px;
    assign o_data.py    = r_py;
    assign o_data.depth = r_dep3;

endmodule

/* src/dphm_rotate.sv */
`timescale 1ns / 1ps
// rotation: nine coefficient products, then three row sums
// two register stages; depends on dphm_pkg

module dphm_rotate (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dphm_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  dphm_pkg::t_proj      i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output dphm_pkg::t_rot       o_data
);
    import dphm_pkg::*;

    logic [1:0] w_stall;
    logic [1:0] r_vld, n_vld;

    logic                    r_skip4, n_skip4, r_skip5, n_skip5;
    logic signed [PA_W-1:0]  r_pa [3];
    logic signed [PA_W-1:0]  n_pa [3];
    logic signed [PA_W-1:0]  r_pb [3];
    logic signed [PA_W-1:0]  n_pb [3];
    logic signed [PZ_W-1:0]  r_pc [3];
    logic signed [PZ_W-1:0]  n_pc [3];
    logic signed [R_W-1:0]   r_sum [3];
    logic signed [R_W-1:0]   n_sum [3];

    always_comb begin
        w_stall[1] = r_vld[1] & i_stall;
        w_stall[0] = r_vld[0] & w_stall[1];
    end

    // one lane per matrix row
    always_comb begin
        n_vld   = {r_vld[0], i_valid};
        n_skip4 = i_data.skip;
        n_skip5 = r_skip4;
        for (int i = 0; i < 3; i++) begin
            n_pa[i] = $signed(i_cfg.rot[i][15:0]) * i_data.px;
            n_pb[i] = $signed(i_cfg.rot[i][31:16]) * i_data.py;
            n_pc[i] = $signed(i_cfg.rot[i][47:32]) * $signed({1'b0, i_data.depth});
            // depth is in whole millimetres, so its product shifts up by 20 to match the Q20 point
            n_sum[i] = R_W'(r_pa[i]) + R_W'(r_pb[i]) + (R_W'(r_pc[i]) <<< 20);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < 2; k++) begin
                if (!w_stall[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall[0]) begin
            r_skip4 <= n_skip4;
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= n_pa[i];
                r_pb[i] <= n_pb[i];
                r_pc[i] <= n_pc[i];
            end
        end
        if (!w_stall[1]) begin
            r_skip5 <= n_skip5;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= n_sum[i];
            end
        end
    end

    assign o_stall     = w_stall[0];
    assign o_valid     = r_vld[1];
    assign o_data.skip = r_skip5;
    assign o_data.rx   = r_sum[0];
    assign o_data.ry   = r_sum[1];
    assign o_data.rz   = r_sum[2];

endmodule

/* src/dphm_quant.sv */
`timescale 1ns / 1ps
// quantizer: centimetre truncation, window test, ground band test, output register
// three register stages; depends on dphm_pkg

module dphm_quant (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dphm_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  dphm_pkg::t_rot       i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output dphm_pkg::t_out       o_data
);
    import dphm_pkg::*;

    localparam logic [Q_W-1:0] HALF_W = Q_W'(MAP_WIDTH / 2);
    localparam logic [Q_W-1:0] MAP_H  = Q_W'(MAP_HEIGHT);

    logic [2:0] w_stall;
    logic [2:0] r_vld, n_vld;

    logic signed [R_W-1:0] w_absx, w_absy;
    logic signed [16:0]    w_hi, w_lo;
    logic signed [R_W-1:0] w_hi_q, w_lo_q;
    logic [63:0]           w_mx, w_my;
    logic                  w_in_win;
    logic [Q_W-1:0]        w_col;

    logic           r_skip6, n_skip6, r_skip7, n_skip7;
    logic           r_gl6, n_gl6, r_gl7, n_gl7;
    logic           r_sx6, n_sx6, r_sy6, n_sy6, r_sx7, n_sx7, r_sy7, n_sy7;
    logic [31:0]    r_hx, n_hx, r_hy, n_hy;
    logic [Q_W-1:0] r_qx, n_qx, r_qy, n_qy;
    t_out           r_out, n_out;

    always_comb begin
        w_stall[2] = r_vld[2] & i_stall;
        w_stall[1] = r_vld[1] & w_stall[2];
        w_stall[0] = r_vld[0] & w_stall[1];
    end

    always_comb begin
        n_vld = {r_vld[1], r_vld[0], i_valid};

        // magnitude in whole millimetres; truncation toward zero keeps the sign apart
        n_skip6 = i_data.skip;
        n_sx6   = i_data.rx[R_W-1];
        n_sy6   = i_data.ry[R_W-1];
        w_absx  = n_sx6 ? -i_data.rx : i_data.rx;
        w_absy  = n_sy6 ? -i_data.ry : i_data.ry;
        n_hx    = 32'(w_absx[R_W-1:FRAC_W]);
        n_hy    = 32'(w_absy[R_W-1:FRAC_W]);

        // ground band edges at Q34
        w_hi   = 17'(i_cfg.ground) + $signed({7'd0, i_cfg.band});
        w_lo   = 17'(i_cfg.ground) - $signed({7'd0, i_cfg.band});
        w_hi_q = $signed({{(R_W - 17 - FRAC_W){w_hi[16]}}, w_hi, {FRAC_W{1'b0}}});
        w_lo_q = $signed({{(R_W - 17 - FRAC_W){w_lo[16]}}, w_lo, {FRAC_W{1'b0}}});
        n_gl6  = ((i_data.rz < w_hi_q) && (i_data.rz > w_lo_q)) || (i_data.rz == '0);

        // millimetres to centimetres by reciprocal multiply
        w_mx    = 64'(r_hx) * 64'(DIV10_MAGIC);
        w_my    = 64'(r_hy) * 64'(DIV10_MAGIC);
        n_qx    = w_mx[DIV10_SHIFT +: Q_W];
        n_qy    = w_my[DIV10_SHIFT +: Q_W];
        n_sx7   = r_sx6;
        n_sy7   = r_sy6;
        n_gl7   = r_gl6;
        n_skip7 = r_skip6;

        // window: |x| below half width, y strictly negative and above minus height
        w_in_win = (r_qx < HALF_W) && r_sy7 && (r_qy != '0) && (r_qy < MAP_H);
        w_col    = r_sx7 ? (HALF_W - r_qx) : (HALF_W + r_qx);

        n_out = '0;
        if (!r_skip7 && w_in_win && i_cfg.gnd_valid) begin
            n_out.write_enable = 1'b1;
            n_out.map_row      = r_qy[7:0];
            n_out.map_col      = w_col[7:0];
            n_out.cell_value   = r_gl7 ? CELL_GROUND : CELL_OBSTACLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (!w_stall[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall[0]) begin
            r_skip6 <= n_skip6;
            r_sx6   <= n_sx6;
            r_sy6   <= n_sy6;
            r_hx    <= n_hx;
            r_hy    <= n_hy;
            r_gl6   <= n_gl6;
        end
        if (!w_stall[1]) begin
            r_skip7 <= n_skip7;
            r_sx7   <= n_sx7;
            r_sy7   <= n_sy7;
            r_qx    <= n_qx;
            r_qy    <= n_qy;
            r_gl7   <= n_gl7;
        end
        if (!w_stall[2]) begin
            r_out <= n_out;
        end
    end

    assign o_stall = w_stall[0];
    assign o_valid = r_vld[2];
    assign o_data  = r_out;

endmodule

/* src/depth_pixel_height_map_projection.sv */
`timescale 1ns / 1ps
// throughput: one pixel per cycle while the output is not stalled; every pixel gives exactly one result transfer
// eight register stages: three for back-projection (offset, times depth, times 1/f),
// two for the coefficient products and row sums, three for the divide by ten and tests
// reset (synchronous, active low) empties every stage and loads the register defaults
// depends on dphm_pkg, dphm_front, dphm_rotate, dphm_quant

module depth_pixel_height_map_projection (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_idx,
    input  logic [dphm_pkg::CFG_W-1:0] i_cfg_data,
    // pixel input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  dphm_pkg::t_in             i_in_data,
    // map cell output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output dphm_pkg::t_out            o_out_data
);
    import dphm_pkg::*;

    // configuration registers, held at their own widths
    logic [19:0]        r_principal;
    logic [31:0]        r_inv_focal;
    logic [47:0]        r_rot0, r_rot1, r_rot2;
    logic [14:0]        r_ground;
    logic [9:0]         r_band;
    logic               r_gnd_valid;

    t_cfg               w_cfg;

    // stage handshakes between the three parts
    logic               w_fr_valid, w_fr_stall;
    t_proj              w_fr_data;
    logic               w_ro_valid, w_ro_stall;
    t_rot               w_ro_data;

    // register decode; the user must write only while the pipeline is empty, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_principal <= RST_PRINCIPAL;
            r_inv_focal <= RST_INV_FOCAL;
            r_rot0      <= RST_ROT_ROW_0;
            r_rot1      <= RST_ROT_ROW_1;
            r_rot2      <= RST_ROT_ROW_2;
            r_ground    <= RST_GROUND;
            r_band      <= RST_BAND;
            r_gnd_valid <= RST_GND_VALID;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_PRINCIPAL: r_principal <= i_cfg_data[19:0];
                REG_INV_FOCAL: r_inv_focal <= i_cfg_data[31:0];
                REG_ROT_ROW_0: r_rot0      <= i_cfg_data[47:0];
                REG_ROT_ROW_1: r_rot1      <= i_cfg_data[47:0];
                REG_ROT_ROW_2: r_rot2      <= i_cfg_data[47:0];
                REG_GROUND:    r_ground    <= i_cfg_data[14:0];
                REG_BAND:      r_band      <= i_cfg_data[9:0];
                REG_GND_VALID: r_gnd_valid <= i_cfg_data[0];
                default:       r_gnd_valid <= r_gnd_valid;
            endcase
        end
    end

    // unpack fields once for all stages
    always_comb begin
        w_cfg.cx        = r_principal[9:0];
        w_cfg.cy        = r_principal[19:10];
        w_cfg.inv_fx    = r_inv_focal[15:0];
        w_cfg.inv_fy    = r_inv_focal[31:16];
        w_cfg.rot[0]    = r_rot0;
        w_cfg.rot[1]    = r_rot1;
        w_cfg.rot[2]    = r_rot2;
        w_cfg.ground    = $signed(r_ground);
        w_cfg.band      = r_band;
        w_cfg.gnd_valid = r_gnd_valid;
    end

    // stages 1-3: pixel filter, offset times depth, times 1/f
    dphm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_valid (w_fr_valid),
        .i_stall (w_fr_stall),
        .o_data  (w_fr_data)
    );

    // stages 4-5: matrix products and row sums
    dphm_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_fr_valid),
        .o_stall (w_fr_stall),
        .i_data  (w_fr_data),
        .o_valid (w_ro_valid),
        .i_stall (w_ro_stall),
        .o_data  (w_ro_data)
    );

    // stages 6-8: centimetre truncation, window and band tests, output register
    dphm_quant u_quant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_ro_valid),
        .o_stall (w_ro_stall),
        .i_data  (w_ro_data),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

/* src/dphm_checker.sv */
`timescale 1ns / 1ps
// port-level checks on the output channel of the height map projection
// depends on dphm_pkg; bound to depth_pixel_height_map_projection

module dphm_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_out_valid,
    input  logic            i_out_stall,
    input  dphm_pkg::t_out  o_out_data
);
    import dphm_pkg::*;

    // a stalled transfer stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    // a stalled transfer keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed under stall");

    // a result without a write carries all zero fields
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_enable |->
            o_out_data.map_row == 8'd0 && o_out_data.map_col == 8'd0
            && o_out_data.cell_value == 8'd0)
        else $error("fields set on a result without a write");

    // a write carries one of the two cell codes
    a_cell_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_enable |->
            o_out_data.cell_value == CELL_GROUND
            || o_out_data.cell_value == CELL_OBSTACLE)
        else $error("unknown cell value on a write");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind depth_pixel_height_map_projection dphm_checker u_dphm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* tb/sv/depth_pixel_height_map_projection_test.sv */
`timescale 1ns / 1ps
// self-checking bench for the depth pixel to height-map cell projection block
// predicts each map cell from a shadow of the registers; needs dphm_pkg and the block rtl

module depth_pixel_height_map_projection_test;

    import dphm_pkg::*;

    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     DRAIN_CYCLES = 12;        // pipeline is 8 deep, a few spare
    localparam int     REPORT_LIMIT = 10;
    localparam longint ONE_Q34      = 64'sd1 <<< 34;
    localparam int     REG_BITS [8] = '{20, 32, 48, 48, 48, 15, 10, 1};

    // every input driven from time zero
    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             cfg_we   = 1'b0;
    logic [2:0]       cfg_idx  = REG_PRINCIPAL;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    t_in              in_data  = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    t_out             out_data;

    // shadow of the register file, loaded with the reset defaults
    logic [47:0] cfg_shadow [8] = '{RST_PRINCIPAL, RST_INV_FOCAL, RST_ROT_ROW_0,
                                    RST_ROT_ROW_1, RST_ROT_ROW_2, RST_GROUND,
                                    RST_BAND, RST_GND_VALID};

    t_out expected_cells [$];
    t_out want_cell;
    bit   no_gaps = 1'b0;            // turns off idling on both channels
    int   stall_left = 0;
    int   cycle_count = 0;
    int   mismatches = 0;
    int   pixels_sent = 0;
    int   settings_loaded = 0;
    int   ground_cells = 0;
    int   obstacle_cells = 0;

    depth_pixel_height_map_projection u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #5 clk = ~clk;

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint rotate_point(logic [47:0] coeffs, longint ax, longint ay,
                                            longint az);
        longint k0, k1, k2;
        k0 = $signed(coeffs[15:0]);
        k1 = $signed(coeffs[31:16]);
        k2 = $signed(coeffs[47:32]);
        return k0 * ax + k1 * ay + k2 * az;
    endfunction

    // map cell that one pixel should produce under the current register shadow
    function automatic t_out project_pixel(t_in pix);
        t_out   res;
        longint row, col, depth, pt_x, pt_y, pt_z, rot_x, rot_y, rot_z;
        longint x_cm, y_cm, gnd, band;
        res   = '0;
        row   = pix.pixel_row;
        col   = pix.pixel_col;
        depth = pix.depth_mm;
        // decimation and frame border
        if (row[0] || col[0] || row >= FRAME_ROWS - 2 || col >= FRAME_COLS - 2)
            return res;
        // back-projection in Q20 mm
        pt_x = (col - longint'(cfg_shadow[REG_PRINCIPAL][9:0])) * depth
               * longint'(cfg_shadow[REG_INV_FOCAL][15:0]);
        pt_y = (row - longint'(cfg_shadow[REG_PRINCIPAL][19:10])) * depth
               * longint'(cfg_shadow[REG_INV_FOCAL][31:16]);
        pt_z = depth <<< 20;
        // rotation gives Q34 mm
        rot_x = rotate_point(cfg_shadow[REG_ROT_ROW_0], pt_x, pt_y, pt_z);
        rot_y = rotate_point(cfg_shadow[REG_ROT_ROW_1], pt_x, pt_y, pt_z);
        rot_z = rotate_point(cfg_shadow[REG_ROT_ROW_2], pt_x, pt_y, pt_z);
        // whole centimetres, truncated toward zero
        x_cm = rot_x / (10 * ONE_Q34);
        y_cm = rot_y / (10 * ONE_Q34);
        if (!(x_cm > -(MAP_WIDTH / 2) && x_cm < MAP_WIDTH / 2 && y_cm < 0
              && y_cm > -MAP_HEIGHT))
            return res;
        if (!cfg_shadow[REG_GND_VALID][0])
            return res;
        gnd  = $signed(cfg_shadow[REG_GROUND][14:0]);
        band = cfg_shadow[REG_BAND][9:0];
        res.write_enable = 1'b1;
        res.map_row      = 8'(-y_cm);
        res.map_col      = 8'(x_cm + MAP_WIDTH / 2);
        // strict band around the ground, or a height of exactly zero
        res.cell_value   = ((rot_z < (gnd + band) * ONE_Q34 && rot_z > (gnd - band) * ONE_Q34)
                            || rot_z == 0) ? CELL_GROUND : CELL_OBSTACLE;
        return res;
    endfunction

    function automatic t_in pixel_at(int row, int col, int depth);
        t_in pix;
        pix.pixel_row = 10'(row);
        pix.pixel_col = 10'(col);
        pix.depth_mm  = 16'(depth);
        return pix;
    endfunction

    // well-formed pixels sit on even rows and columns inside the frame; noise is anything
    function automatic t_in random_pixel(bit noisy);
        int pick;
        int depth;
        if (noisy)
            return pixel_at($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 65535));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            depth = 0;
        else if (pick == 1)
            depth = $urandom_range(0, 65535);
        else
            depth = $urandom_range(200, 3500);
        return pixel_at(2 * $urandom_range(0, (FRAME_ROWS - 4) / 2),
                        2 * $urandom_range(0, (FRAME_COLS - 4) / 2), depth);
    endfunction

    // starts at a falling edge, returns at the rising edge that took the transfer
    task automatic send_pixel(input t_in pix);
        int gap;
        gap = no_gaps ? 0 : random_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pix;
        do @(posedge clk); while (in_stall);
        expected_cells = {expected_cells, project_pixel(pix)};
        pixels_sent++;
    endtask

    // sender goes quiet until every expected cell is back and the pipeline is empty
    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_cells.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // only called with the block idle
    task automatic write_reg(input t_reg_idx idx, input logic [47:0] value);
        logic [47:0] mask;
        mask = (48'd1 << REG_BITS[idx]) - 48'd1;
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_shadow[idx] = value & mask;
    endtask

    task automatic load_config(input int cx, input int cy, input int ifx, input int ify,
                               input logic [47:0] row0, input logic [47:0] row1,
                               input logic [47:0] row2, input int ground, input int band,
                               input bit gnd_ok);
        write_reg(REG_PRINCIPAL, 48'({cy[9:0], cx[9:0]}));
        write_reg(REG_INV_FOCAL, 48'({ify[15:0], ifx[15:0]}));
        write_reg(REG_ROT_ROW_0, row0);
        write_reg(REG_ROT_ROW_1, row1);
        write_reg(REG_ROT_ROW_2, row2);
        write_reg(REG_GROUND, 48'(ground));
        write_reg(REG_BAND, 48'(band));
        write_reg(REG_GND_VALID, 48'(gnd_ok));
        settings_loaded++;
    endtask

    // camera-like setup: near-identity rotation with random tilt and sign flips
    task automatic load_random_camera();
        logic [15:0] k [9];
        int          i;
        int          focal_x;
        for (i = 0; i < 9; i++) begin
            k[i] = 16'(int'($urandom_range(0, 4000)) - 2000);
            if (i % 4 == 0)
                k[i] = k[i] + (($urandom_range(0, 3) == 0) ? 16'hC000 : 16'h4000);
        end
        focal_x = $urandom_range(1200, 3500);
        load_config($urandom_range(200, 650), $urandom_range(100, 400), focal_x,
                    $urandom_range(1200, 3500), {k[2], k[1], k[0]}, {k[5], k[4], k[3]},
                    {k[8], k[7], k[6]}, $urandom_range(300, 3000), $urandom_range(0, 1000),
                    $urandom_range(0, 9) != 0);
    endtask

    // defaults after reset: no writes until the ground is marked valid
    task automatic test_reset_defaults();
        send_pixel(pixel_at(0, 0, 1000));
        send_pixel(pixel_at(1023, 1023, 65535));
        wait_all_results();
        write_reg(REG_GND_VALID, 48'd1);
        send_pixel(pixel_at(100, 418, 1000));
        wait_all_results();
    endtask

    // with unit-scaled optics x = (col - cx) / 2 and y = (row - cy) / 2 in cm
    task automatic test_window_edges();
        load_config(400, 400, 1024, 1024, RST_ROT_ROW_0, RST_ROT_ROW_1, RST_ROT_ROW_2,
                    5120, 1, 1'b1);
        send_pixel(pixel_at(398, 400, 5120));   // y just below zero
        send_pixel(pixel_at(400, 400, 5120));   // y zero, outside
        send_pixel(pixel_at(2, 400, 5120));     // deepest row inside
        send_pixel(pixel_at(0, 400, 5120));     // one past the far edge
        send_pixel(pixel_at(398, 598, 5120));   // right edge inside
        send_pixel(pixel_at(398, 600, 5120));   // right edge outside
        send_pixel(pixel_at(398, 202, 5120));   // left edge inside
        send_pixel(pixel_at(398, 200, 5120));   // left edge outside
        wait_all_results();
        // odd centre: half centimetres must truncate toward zero
        load_config(401, 401, 1024, 1024, RST_ROT_ROW_0, RST_ROT_ROW_1, RST_ROT_ROW_2,
                    5120, 1, 1'b1);
        send_pixel(pixel_at(398, 202, 5120));
        send_pixel(pixel_at(400, 402, 5120));
        wait_all_results();
        // frame border, with a centre that keeps the corner inside the map
        load_config(845, 1023, 1024, 1024, RST_ROT_ROW_0, RST_ROT_ROW_1, RST_ROT_ROW_2,
                    5120, 1, 1'b1);
        send_pixel(pixel_at(476, 844, 1024));
        send_pixel(pixel_at(478, 844, 1024));
        send_pixel(pixel_at(476, 846, 1024));
        send_pixel(pixel_at(1022, 1022, 65535));
        send_pixel(pixel_at(476, 844, 0));      // no reading lands on the origin
        wait_all_results();
    endtask

    // band edges are strict; a rotated height of exactly zero always counts as ground
    task automatic test_ground_band();
        load_config(400, 400, 1024, 1024, RST_ROT_ROW_0, RST_ROT_ROW_1, RST_ROT_ROW_2,
                    1000, 30, 1'b1);
        send_pixel(pixel_at(200, 400, 1029));
        send_pixel(pixel_at(200, 400, 1030));
        send_pixel(pixel_at(200, 400, 971));
        send_pixel(pixel_at(200, 400, 970));
        wait_all_results();
        write_reg(REG_BAND, 48'd0);
        send_pixel(pixel_at(200, 400, 1000));
        wait_all_results();
        write_reg(REG_ROT_ROW_2, 48'd0);
        write_reg(REG_GROUND, 48'h3FFF);
        send_pixel(pixel_at(200, 400, 1000));
        wait_all_results();
        write_reg(REG_ROT_ROW_2, RST_ROT_ROW_2);
        write_reg(REG_GROUND, 48'h4000);
        write_reg(REG_BAND, 48'd1023);
        send_pixel(pixel_at(200, 400, 1000));
        wait_all_results();
    endtask

    // phases of random traffic: camera setups, all-zero and all-one registers,
    // one phase without idling and one with a mid-stream hold-off
    task automatic test_random_stream();
        int phase;
        int n;
        int count;
        int r;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                2: begin
                    load_config(0, 0, 0, 0, '0, '0, '0, 0, 0, 1'b1);
                end
                3: begin
                    for (r = 0; r < 8; r++)
                        write_reg(t_reg_idx'(r), '1);
                    settings_loaded++;
                end
                default: begin
                    load_random_camera();
                end
            endcase
            no_gaps = (phase == 1);
            count   = (phase == 2 || phase == 3) ? 125 : 300;
            for (n = 0; n < count; n++) begin
                if (phase == 4 && n == count / 2)
                    wait_all_results();
                send_pixel(random_pixel($urandom_range(0, 99) < 15));
            end
            wait_all_results();
        end
        no_gaps = 1'b0;
    endtask

    // receiver stalls in bursts of random length
    always @(negedge clk) begin
        if (stall_left == 0 && !no_gaps)
            stall_left = random_gap();
        if (stall_left > 0 && !no_gaps) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // every accepted result against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected transfer at %0t: we=%0b row=%0d col=%0d value=%0d",
                             $realtime, out_data.write_enable, out_data.map_row,
                             out_data.map_col, out_data.cell_value);
            end else begin
                want_cell = expected_cells.pop_front();
                if (out_data.write_enable !== want_cell.write_enable
                    || out_data.map_row !== want_cell.map_row
                    || out_data.map_col !== want_cell.map_col
                    || out_data.cell_value !== want_cell.cell_value) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch at %0t: expected we=%0b row=%0d col=%0d value=%0d",
                                 $realtime, want_cell.write_enable, want_cell.map_row,
                                 want_cell.map_col, want_cell.cell_value);
                        $display("    got we=%0b row=%0d col=%0d value=%0d",
                                 out_data.write_enable, out_data.map_row,
                                 out_data.map_col, out_data.cell_value);
                    end
                end
                if (out_data.write_enable === 1'b1) begin
                    if (out_data.cell_value === CELL_GROUND)
                        ground_cells++;
                    else
                        obstacle_cells++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_window_edges();
        test_ground_band();
        test_random_stream();
        $display("run covered %0d pixel transfers over %0d register setups", pixels_sent,
                 settings_loaded);
        $display("map writes observed: %0d ground cells, %0d obstacle cells", ground_cells,
                 obstacle_cells);
        if (mismatches == 0 && expected_cells.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* depth_pixel_height_map_projection.f */
src/dphm_pkg.sv
src/dphm_front.sv
src/dphm_rotate.sv
src/dphm_quant.sv
src/depth_pixel_height_map_projection.sv
src/dphm_checker.sv
tb/sv/depth_pixel_height_map_projection_test.sv
